FILE: sv/aip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aip_pkg;

    localparam int MAX_WIDTH = 64;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_UC_O  = 8'h4F;
    localparam logic [7:0] CH_UC_X  = 8'h58;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_O  = 8'h6F;
    localparam logic [7:0] CH_LC_X  = 8'h78;

    localparam logic CFG_WIDTH_CODE    = 1'b0;
    localparam logic CFG_SIGNED_TARGET = 1'b1;

    localparam logic [1:0] WIDTH_CODE_RESET = 2'd2;
    localparam logic       SIGNED_RESET     = 1'b1;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_SIGN,
        PH_ZERO,
        PH_PREFIX,
        PH_BODY,
        PH_TRAIL,
        PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC,
        RX_HEX,
        RX_OCT
    } radix_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_PARSE,
        ST_NEG_UNSIGNED
    } status_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } char_item_t;

    typedef struct packed {
        logic [63:0] magnitude;
        logic        negate;
        logic [1:0]  width_code;
        logic        signed_target;
        status_t     status;
    } res_raw_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    endfunction

    function automatic logic [63:0] width_mask(input logic [1:0] wc);
        int bits;
        bits = 8 << wc;
        if (bits > MAX_WIDTH)
        begin
            bits = MAX_WIDTH;
        end
        if (bits >= 64)
        begin
            return '1;
        end
        return (64'd1 << bits) - 64'd1;
    endfunction

    // bit 4 flags a valid digit of the radix, bits 3:0 hold its value
    function automatic logic [4:0] digit_value(input logic [7:0] c, input radix_t rx);
        logic [7:0] d;
        logic       ok;
        d  = 8'd0;
        ok = 1'b0;
        if (c inside {[CH_ZERO:CH_NINE]})
        begin
            d  = c - CH_ZERO;
            ok = 1'b1;
        end
        else if (c inside {[CH_LC_A:CH_LC_F]})
        begin
            d  = c - CH_LC_A + 8'd10;
            ok = 1'b1;
        end
        else if (c inside {[CH_UC_A:CH_UC_F]})
        begin
            d  = c - CH_UC_A + 8'd10;
            ok = 1'b1;
        end
        case (rx)
            RX_HEX:  ok = ok;
            RX_OCT:  ok = ok && (d < 8'd8);
            default: ok = ok && (d < 8'd10);
        endcase
        return {ok, d[3:0]};
    endfunction

endpackage

`default_nettype wire

FILE: sv/aip_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module aip_in_stage
    import aip_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       char_valid,
    output logic            char_ready,
    input  wire logic [7:0] char_code,
    input  wire logic       last_char,
    input  wire logic       take,
    output logic            item_valid,
    output char_item_t      item
);

    logic       item_valid_reg;
    logic       item_valid_next;
    char_item_t item_reg;

    assign char_ready = !item_valid_reg || take;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (char_ready)
        begin
            item_valid_next = char_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
        begin
            item_reg.char_code <= char_code;
            item_reg.last_char <= last_char;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

FILE: sv/aip_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module aip_parse
    import aip_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    input  wire char_item_t item,
    input  wire logic       out_free,
    input  wire logic [1:0] width_code,
    input  wire logic       signed_target,
    output logic            take,
    output logic            result_load,
    output res_raw_t        result
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic        outer_neg_reg;
    logic        outer_neg_next;
    logic        inner_neg_reg;
    logic        inner_neg_next;
    radix_t      radix_reg;
    radix_t      radix_next;
    logic        digit_seen_reg;
    logic        digit_seen_next;
    logic        range_err_reg;
    logic        range_err_next;

    logic [7:0]  c;
    logic        sp;
    logic [4:0]  dv;
    logic        do_digit;
    logic [63:0] mask;
    logic [63:0] half;
    logic [63:0] lim;
    logic        neg;
    logic [67:0] acc_wide;
    logic [67:0] prod;
    status_t     st;

    assign take        = item_valid && (!item.last_char || out_free);
    assign result_load = take && item.last_char;

    assign c    = item.char_code;
    assign sp   = is_space(c);
    assign dv   = digit_value(c, radix_reg);
    assign mask = width_mask(width_code);
    assign half = mask ^ (mask >> 1);
    assign neg  = (radix_reg == RX_DEC) ? (outer_neg_reg ^ inner_neg_reg) : inner_neg_reg;
    assign lim  = !signed_target ? mask : (neg ? half : half - 64'd1);

    // acc * radix + digit, compared against the limit without overflow
    assign acc_wide = {4'b0, acc_reg};
    always_comb
    begin
        case (radix_reg)
            RX_HEX:  prod = (acc_wide << 4) + {64'd0, dv[3:0]};
            RX_OCT:  prod = (acc_wide << 3) + {64'd0, dv[3:0]};
            default: prod = (acc_wide << 3) + (acc_wide << 1) + {64'd0, dv[3:0]};
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        acc_next        = acc_reg;
        outer_neg_next  = outer_neg_reg;
        inner_neg_next  = inner_neg_reg;
        radix_next      = radix_reg;
        digit_seen_next = digit_seen_reg;
        range_err_next  = range_err_reg;
        do_digit        = 1'b0;

        case (phase_reg)
            PH_LEAD, PH_SIGN:
            begin
                if (sp)
                begin
                    if (phase_reg == PH_SIGN)
                    begin
                        phase_next = PH_TRAIL;
                    end
                end
                else if (phase_reg == PH_LEAD && (c == CH_PLUS || c == CH_MINUS))
                begin
                    outer_neg_next = (c == CH_MINUS);
                    phase_next     = PH_SIGN;
                end
                else if (phase_reg == PH_SIGN && c == CH_MINUS)
                begin
                    if (!outer_neg_reg && signed_target)
                    begin
                        inner_neg_next = 1'b1;
                        phase_next     = PH_BODY;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                    end
                end
                else if (dv[4])
                begin
                    do_digit = 1'b1;
                end
                else
                begin
                    phase_next = PH_ERROR;
                end
            end
            PH_ZERO:
            begin
                if (sp)
                begin
                    phase_next = PH_TRAIL;
                end
                else if (c == CH_LC_X || c == CH_UC_X || c == CH_LC_O || c == CH_UC_O)
                begin
                    radix_next      = (c == CH_LC_X || c == CH_UC_X) ? RX_HEX : RX_OCT;
                    digit_seen_next = 1'b0;
                    acc_next        = 64'd0;
                    phase_next      = PH_PREFIX;
                end
                else if (dv[4])
                begin
                    do_digit = 1'b1;
                end
                else
                begin
                    phase_next = PH_ERROR;
                end
            end
            PH_PREFIX:
            begin
                if (sp)
                begin
                    phase_next = PH_TRAIL;
                end
                else if (c == CH_MINUS)
                begin
                    if (signed_target)
                    begin
                        inner_neg_next = 1'b1;
                        phase_next     = PH_BODY;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                    end
                end
                else if (dv[4])
                begin
                    do_digit = 1'b1;
                end
                else
                begin
                    phase_next = PH_ERROR;
                end
            end
            PH_BODY:
            begin
                if (sp)
                begin
                    phase_next = PH_TRAIL;
                end
                else if (dv[4])
                begin
                    do_digit = 1'b1;
                end
                else
                begin
                    phase_next = PH_ERROR;
                end
            end
            PH_TRAIL:
            begin
                if (!sp)
                begin
                    phase_next = PH_ERROR;
                end
            end
            default:
            begin
                phase_next = PH_ERROR;
            end
        endcase

        if (do_digit)
        begin
            digit_seen_next = 1'b1;
            // a leading zero may still open a radix prefix
            phase_next = (phase_reg == PH_LEAD || phase_reg == PH_SIGN) && c == CH_ZERO
                         ? PH_ZERO : PH_BODY;
            if (!range_err_reg)
            begin
                if (prod > {4'b0, lim})
                begin
                    range_err_next = 1'b1;
                end
                else
                begin
                    acc_next = prod[63:0];
                end
            end
        end
    end

    always_comb
    begin
        if (phase_next == PH_ERROR || !digit_seen_next || range_err_next)
        begin
            st = ST_PARSE;
        end
        else if (!signed_target && (outer_neg_next || inner_neg_next))
        begin
            st = (radix_next == RX_DEC || inner_neg_next) ? ST_PARSE : ST_NEG_UNSIGNED;
        end
        else
        begin
            st = ST_OK;
        end
        result.magnitude     = acc_next;
        result.negate        = outer_neg_next ^ inner_neg_next;
        result.width_code    = width_code;
        result.signed_target = signed_target;
        result.status        = st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LEAD;
            acc_reg        <= 64'd0;
            outer_neg_reg  <= 1'b0;
            inner_neg_reg  <= 1'b0;
            radix_reg      <= RX_DEC;
            digit_seen_reg <= 1'b0;
            range_err_reg  <= 1'b0;
        end
        else if (take)
        begin
            if (item.last_char)
            begin
                phase_reg      <= PH_LEAD;
                acc_reg        <= 64'd0;
                outer_neg_reg  <= 1'b0;
                inner_neg_reg  <= 1'b0;
                radix_reg      <= RX_DEC;
                digit_seen_reg <= 1'b0;
                range_err_reg  <= 1'b0;
            end
            else
            begin
                phase_reg      <= phase_next;
                acc_reg        <= acc_next;
                outer_neg_reg  <= outer_neg_next;
                inner_neg_reg  <= inner_neg_next;
                radix_reg      <= radix_next;
                digit_seen_reg <= digit_seen_next;
                range_err_reg  <= range_err_next;
            end
        end
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        result_load |=> (phase_reg == PH_LEAD && acc_reg == 64'd0 && !digit_seen_reg))
        else $error("parse state not cleared after final character");

    assert property (@(posedge clk) disable iff (!rst_n)
        (range_err_reg && !result_load) |=> ($stable(acc_reg) && range_err_reg))
        else $error("accumulator moved after range error");

    assert property (@(posedge clk) disable iff (!rst_n)
        (radix_reg != RX_DEC) |-> (phase_reg == PH_PREFIX || phase_reg == PH_BODY
                                   || phase_reg == PH_TRAIL || phase_reg == PH_ERROR))
        else $error("radix prefix outside number body");
`endif

endmodule

`default_nettype wire

FILE: sv/aip_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module aip_out_stage
    import aip_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire res_raw_t    raw,
    output logic             out_free,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [63:0]      value,
    output logic [1:0]       status
);

    logic        res_valid_reg;
    logic        res_valid_next;
    res_raw_t    res_reg;
    logic [63:0] mask;
    logic [63:0] half;
    logic [63:0] signed_val;
    logic [63:0] fitted;

    assign out_free = !res_valid_reg || result_ready;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (load)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= raw;
        end
    end

    // wrap to target width, then sign-extend for a signed target
    assign mask       = width_mask(res_reg.width_code);
    assign half       = mask ^ (mask >> 1);
    assign signed_val = res_reg.negate ? (64'd0 - res_reg.magnitude) : res_reg.magnitude;
    assign fitted     = ((signed_val & mask) | ((res_reg.signed_target && ((signed_val & half) != 64'd0))
                         ? ~mask : 64'd0));

    assign result_valid = res_valid_reg;
    assign value        = (res_reg.status == ST_OK) ? fitted : 64'd0;
    assign status       = res_reg.status;

endmodule

`default_nettype wire

FILE: sv/ascii_integer_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// ascii_integer_parser reads a text field one character per transfer, the final character
// marked by last_char, and returns one result per field: the integer, sign-extended to
// 64 bits for a signed target, and a status (0 ok, 1 parse error or out of range, 2 a
// minus sign before a 0x or 0o prefix for an unsigned target). Decimal, 0x/0X hexadecimal
// and 0o/0O octal are accepted, with an optional sign and surrounding whitespace. A
// character is accepted every cycle; the final character waits in an input register until
// the parse logic moves it into the result register and clears the parse state.
// Only the final character of a field waits while an earlier result is still unaccepted.
// The user must write width_code and signed_target through the cfg port only while no
// character or result is in flight; the block itself does not enforce this.

module ascii_integer_parser
    import aip_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [1:0]  cfg_data,
    input  wire logic        char_valid,
    output logic             char_ready,
    input  wire logic [7:0]  char_code,
    input  wire logic        last_char,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [63:0]      value,
    output logic [1:0]       status
);

    logic [1:0] width_code_reg;
    logic       signed_target_reg;
    logic       take;
    logic       item_valid;
    char_item_t item;
    logic       out_free;
    logic       result_load;
    res_raw_t   raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_code_reg    <= WIDTH_CODE_RESET;
            signed_target_reg <= SIGNED_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_WIDTH_CODE:    width_code_reg    <= cfg_data;
                CFG_SIGNED_TARGET: signed_target_reg <= cfg_data[0];
                default:           width_code_reg    <= width_code_reg;
            endcase
        end
    end

    aip_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_code  (char_code),
        .last_char  (last_char),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    aip_parse u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item          (item),
        .out_free      (out_free),
        .width_code    (width_code_reg),
        .signed_target (signed_target_reg),
        .take          (take),
        .result_load   (result_load),
        .result        (raw)
    );

    aip_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (result_load),
        .raw          (raw),
        .out_free     (out_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .value        (value),
        .status       (status)
    );

endmodule

`default_nettype wire

FILE: dv/ascii_integer_parser_tb.sv
`timescale 1ns / 1ps

module ascii_integer_parser_tb;

    import aip_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;

    typedef struct {
        logic [63:0] num;
        status_t     status;
    } parse_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic        cfg_index = CFG_WIDTH_CODE;
    logic [1:0]  cfg_data = 2'd0;
    logic        char_valid = 1'b0;
    logic        char_ready;
    logic [7:0]  char_code = 8'd0;
    logic        last_char = 1'b0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [63:0] value;
    logic [1:0]  status;

    // parser state as the block should hold it
    phase_t      prs_phase;
    logic [63:0] prs_acc;
    logic        prs_outer_neg;
    logic        prs_inner_neg;
    radix_t      prs_radix;
    logic        prs_digit_seen;
    logic        prs_range_err;
    logic [1:0]  target_wc;
    logic        target_signed;

    parse_result_t expected_results[$];
    parse_result_t oldest_result;
    logic [7:0]    field_bytes[$];

    int  errors = 0;
    int  chars_sent = 0;
    int  fields_sent = 0;
    int  results_checked = 0;
    int  settings_used = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    bit  hold_request = 1'b0;
    bit  steady_flow = 1'b0;

    ascii_integer_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_code    (char_code),
        .last_char    (last_char),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .value        (value),
        .status       (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // --------------------------------------------------------------------
    // integer parse predictor

    function automatic int unsigned target_width();
        return 8 << target_wc;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic int unsigned digit_of(input logic [7:0] c);
        int unsigned d;
        d = 255;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            d = c - CH_ZERO;
        end
        else if (c >= CH_LC_A && c <= CH_LC_F)
        begin
            d = c - CH_LC_A + 10;
        end
        else if (c >= CH_UC_A && c <= CH_UC_F)
        begin
            d = c - CH_UC_A + 10;
        end
        if (prs_radix == RX_HEX)
        begin
            return d;
        end
        if (prs_radix == RX_OCT)
        begin
            return (d < 8) ? d : 255;
        end
        return (d < 10) ? d : 255;
    endfunction

    function automatic void clear_parse();
        prs_phase      = PH_LEAD;
        prs_acc        = '0;
        prs_outer_neg  = 1'b0;
        prs_inner_neg  = 1'b0;
        prs_radix      = RX_DEC;
        prs_digit_seen = 1'b0;
        prs_range_err  = 1'b0;
    endfunction

    function automatic void take_digit(input int unsigned d);
        int unsigned w;
        logic [63:0] r;
        logic [63:0] half;
        logic [63:0] mask;
        logic [63:0] lim;
        logic        neg;
        w    = target_width();
        r    = (prs_radix == RX_HEX) ? 64'd16 : ((prs_radix == RX_OCT) ? 64'd8 : 64'd10);
        half = 64'd1 << (w - 1);
        mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        neg  = (prs_radix == RX_DEC) ? (prs_outer_neg ^ prs_inner_neg) : prs_inner_neg;
        lim  = !target_signed ? mask : (neg ? half : half - 64'd1);
        prs_digit_seen = 1'b1;
        prs_phase      = PH_BODY;
        if (!prs_range_err)
        begin
            if (prs_acc > (lim - 64'(d)) / r)
            begin
                prs_range_err = 1'b1;
            end
            else
            begin
                prs_acc = prs_acc * r + 64'(d);
            end
        end
    endfunction

    function automatic void take_char(input logic [7:0] c);
        int unsigned d;
        case (prs_phase)
            PH_LEAD, PH_SIGN:
            begin
                if (is_blank(c))
                begin
                    if (prs_phase == PH_SIGN)
                    begin
                        prs_phase = PH_TRAIL;
                    end
                end
                else if (prs_phase == PH_LEAD && (c == CH_PLUS || c == CH_MINUS))
                begin
                    prs_outer_neg = (c == CH_MINUS);
                    prs_phase     = PH_SIGN;
                end
                else if (prs_phase == PH_SIGN && c == CH_MINUS)
                begin
                    if (!prs_outer_neg && target_signed)
                    begin
                        prs_inner_neg = 1'b1;
                        prs_phase     = PH_BODY;
                    end
                    else
                    begin
                        prs_phase = PH_ERROR;
                    end
                end
                else if (c == CH_ZERO)
                begin
                    take_digit(0);
                    prs_phase = PH_ZERO;
                end
                else if (c >= CH_ONE && c <= CH_NINE)
                begin
                    take_digit(c - CH_ZERO);
                end
                else
                begin
                    prs_phase = PH_ERROR;
                end
            end
            PH_ZERO:
            begin
                if (is_blank(c))
                begin
                    prs_phase = PH_TRAIL;
                end
                else if (c == CH_LC_X || c == CH_UC_X || c == CH_LC_O || c == CH_UC_O)
                begin
                    prs_radix      = (c == CH_LC_X || c == CH_UC_X) ? RX_HEX : RX_OCT;
                    prs_digit_seen = 1'b0;
                    prs_acc        = '0;
                    prs_phase      = PH_PREFIX;
                end
                else
                begin
                    d = digit_of(c);
                    if (d == 255)
                        prs_phase = PH_ERROR;
                    else
                        take_digit(d);
                end
            end
            PH_PREFIX:
            begin
                if (is_blank(c))
                begin
                    prs_phase = PH_TRAIL;
                end
                else if (c == CH_MINUS)
                begin
                    if (target_signed)
                    begin
                        prs_inner_neg = 1'b1;
                        prs_phase     = PH_BODY;
                    end
                    else
                    begin
                        prs_phase = PH_ERROR;
                    end
                end
                else
                begin
                    d = digit_of(c);
                    if (d == 255)
                        prs_phase = PH_ERROR;
                    else
                        take_digit(d);
                end
            end
            PH_BODY:
            begin
                if (is_blank(c))
                begin
                    prs_phase = PH_TRAIL;
                end
                else
                begin
                    d = digit_of(c);
                    if (d == 255)
                        prs_phase = PH_ERROR;
                    else
                        take_digit(d);
                end
            end
            PH_TRAIL:
            begin
                if (!is_blank(c))
                begin
                    prs_phase = PH_ERROR;
                end
            end
            default:
            begin
                prs_phase = PH_ERROR;
            end
        endcase
    endfunction

    function automatic void parse_char(input logic [7:0] c, input logic lst);
        int unsigned   w;
        logic [63:0]   mask;
        logic [63:0]   v;
        parse_result_t res;
        take_char(c);
        if (lst)
        begin
            w    = target_width();
            mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
            v    = '0;
            res.status = ST_OK;
            if (prs_phase == PH_ERROR || !prs_digit_seen || prs_range_err)
            begin
                res.status = ST_PARSE;
            end
            else if (!target_signed && (prs_outer_neg || prs_inner_neg))
            begin
                res.status = (prs_radix == RX_DEC || prs_inner_neg) ? ST_PARSE : ST_NEG_UNSIGNED;
            end
            else
            begin
                v = prs_acc;
                if (prs_outer_neg ^ prs_inner_neg)
                begin
                    v = 64'd0 - v;
                end
                v = v & mask;
                if (target_signed && w < 64 && v[w - 1])
                begin
                    v = v | ~mask;
                end
            end
            res.num = (res.status == ST_OK) ? v : 64'd0;
            expected_results = {expected_results, res};
            clear_parse();
        end
    endfunction

    // --------------------------------------------------------------------
    // result side

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else if (steady_flow)
        begin
            result_ready <= 1'b1;
        end
        else
        begin
            result_ready <= ($urandom_range(99) >= 26);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result, value", value, 64'd0);
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                if (value !== oldest_result.num)
                begin
                    report_mismatch("value", value, oldest_result.num);
                end
                if (status !== oldest_result.status)
                begin
                    report_mismatch("status", 64'(status), 64'(oldest_result.status));
                end
                results_checked++;
            end
        end
    end

    // --------------------------------------------------------------------
    // character side

    task automatic send_char(input logic [7:0] c, input logic lst);
        if (!steady_flow && $urandom_range(99) < 35)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_code  <= c;
        last_char  <= lst;
        @(posedge clk);
        while (!char_ready)
        begin
            @(posedge clk);
        end
        parse_char(c, lst);
        chars_sent++;
        if (lst)
        begin
            fields_sent++;
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i], i == s.len() - 1);
        end
    endtask

    task automatic send_field_bytes();
        for (int i = 0; i < field_bytes.size(); i++)
        begin
            send_char(field_bytes[i], i == field_bytes.size() - 1);
        end
    endtask

    task automatic wait_for_results();
        char_valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input logic [1:0] wc, input logic sg);
        wait_for_results();
        cfg_write <= 1'b1;
        cfg_index <= CFG_WIDTH_CODE;
        cfg_data  <= wc;
        @(posedge clk);
        target_wc = wc;
        cfg_index <= CFG_SIGNED_TARGET;
        cfg_data  <= {1'b0, sg};
        @(posedge clk);
        target_signed = sg;
        cfg_write <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // --------------------------------------------------------------------
    // random field builder

    function automatic void add_byte(input logic [7:0] b);
        field_bytes = {field_bytes, b};
    endfunction

    function automatic logic [7:0] blank_char();
        int unsigned k;
        k = $urandom_range(5);
        return (k == 5) ? CH_SPACE : 8'(CH_TAB + k);
    endfunction

    function automatic logic [7:0] digit_char(input int unsigned d);
        if (d < 10)
        begin
            return 8'(CH_ZERO + d);
        end
        return $urandom_range(1) ? 8'(CH_LC_A + d - 10) : 8'(CH_UC_A + d - 10);
    endfunction

    task automatic make_field();
        int unsigned roll;
        int unsigned w;
        int unsigned rdx;
        int unsigned len;
        logic [63:0] half;
        logic [63:0] mask;
        logic [63:0] mag;
        bit          overflow_digit;
        string       s;
        field_bytes.delete();
        roll = $urandom_range(99);
        w    = target_width();
        if (roll < 6)
        begin
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(255)));
        end
        else if (roll < 9)
        begin
            repeat ($urandom_range(1, 3)) add_byte(blank_char());
        end
        else
        begin
            if ($urandom_range(1))
            begin
                repeat ($urandom_range(1, 2)) add_byte(blank_char());
            end
            case ($urandom_range(19))
                10, 11, 12, 13:
                begin
                    add_byte(CH_MINUS);
                end
                14, 15:
                begin
                    add_byte(CH_PLUS);
                end
                16:
                begin
                    add_byte(CH_PLUS);
                    add_byte(CH_MINUS);
                end
                17:
                begin
                    add_byte(CH_MINUS);
                    add_byte(CH_MINUS);
                end
                18:
                begin
                    add_byte(CH_MINUS);
                    add_byte(CH_PLUS);
                end
                19:
                begin
                    add_byte(CH_PLUS);
                    add_byte(CH_PLUS);
                end
                default: ;
            endcase
            rdx = $urandom_range(3);
            if (rdx >= 2)
            begin
                add_byte(CH_ZERO);
                if (rdx == 2)
                    add_byte($urandom_range(1) ? CH_LC_X : CH_UC_X);
                else
                    add_byte($urandom_range(1) ? CH_LC_O : CH_UC_O);
                if ($urandom_range(4) == 0)
                begin
                    add_byte(CH_MINUS);
                end
            end
            if ($urandom_range(3) == 0)
            begin
                // magnitudes around the edges of the target range
                half = 64'd1 << (w - 1);
                mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
                overflow_digit = 1'b0;
                case ($urandom_range(6))
                    0: mag = half - 64'd1;
                    1: mag = half;
                    2: mag = half + 64'd1;
                    3: mag = mask;
                    4: mag = 64'd0;
                    5:
                    begin
                        mag = mask;
                        overflow_digit = (w == 64);
                        if (w < 64) mag = mask + 1;
                    end
                    default:
                    begin
                        mag = mask;
                        overflow_digit = 1'b1;
                    end
                endcase
                if (rdx == 2)
                    s = $sformatf("%0h", mag);
                else if (rdx == 3)
                    s = $sformatf("%0o", mag);
                else
                    s = $sformatf("%0d", mag);
                for (int i = 0; i < s.len(); i++)
                begin
                    if (s[i] >= CH_LC_A && s[i] <= CH_LC_F && $urandom_range(1))
                        add_byte(8'(s[i] - 8'd32));
                    else
                        add_byte(s[i]);
                end
                if (overflow_digit)
                begin
                    add_byte(CH_ONE);
                end
            end
            else
            begin
                if (rdx == 2)
                    len = w / 4 + 1;
                else if (rdx == 3)
                    len = w / 3 + 2;
                else
                    len = (w * 3) / 10 + 2;
                repeat ($urandom_range(1, len))
                begin
                    if (rdx == 2)
                        add_byte(digit_char($urandom_range(15)));
                    else if (rdx == 3)
                        add_byte(digit_char($urandom_range(7)));
                    else
                        add_byte(digit_char($urandom_range(9)));
                end
            end
            if ($urandom_range(1))
            begin
                repeat ($urandom_range(1, 2)) add_byte(blank_char());
            end
            if ($urandom_range(9) == 0)
            begin
                roll = $urandom_range(field_bytes.size() - 1);
                if ($urandom_range(1))
                    field_bytes[roll] = 8'($urandom_range(255));
                else
                    field_bytes.insert(roll, CH_SPACE);
            end
        end
    endtask

    // --------------------------------------------------------------------
    // tests

    task automatic test_reset_config();
        send_text("2147483647");
        send_text("-2147483648");
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_narrow_signed();
        write_config(2'd0, 1'b1);
        send_text("-128");
        send_text("128");
        send_text("999z");
        send_text("-0x-80");
        send_text("0o177");
    endtask

    task automatic test_signs_and_prefixes();
        write_config(2'd1, 1'b1);
        send_text("+-5");
        send_text("--5");
        send_text("-+5");
        send_text("++5");
        send_text("0x");
        send_text("-0o");
        send_text("0X1F");
        send_text("0O-7");
    endtask

    task automatic test_unsigned_signs();
        write_config(2'd3, 1'b0);
        send_text("-0x0");
        send_text("0x-5");
        send_text("-5");
        send_text("+-5");
        send_text("18446744073709551615");
    endtask

    task automatic test_whitespace();
        write_config(2'd2, 1'b1);
        send_text(" \t7\f");
        send_text("1 2");
        send_text(" ");
        send_text("+ 3");
    endtask

    task automatic test_output_backpressure();
        write_config(2'd1, 1'b1);
        steady_flow  = 1'b1;
        hold_request = 1'b1;
        repeat (30) send_text("-9");
        wait_for_results();
        steady_flow = 1'b0;
    endtask

    task automatic test_random_fields(input logic [1:0] wc, input logic sg,
                                      input bit no_idle);
        int start;
        write_config(wc, sg);
        steady_flow = no_idle;
        start = chars_sent;
        while (chars_sent - start < 100)
        begin
            make_field();
            send_field_bytes();
        end
        wait_for_results();
        steady_flow = 1'b0;
    endtask

    initial
    begin
        target_wc     = WIDTH_CODE_RESET;
        target_signed = SIGNED_RESET;
        clear_parse();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_narrow_signed();
        test_signs_and_prefixes();
        test_unsigned_signs();
        test_whitespace();
        test_output_backpressure();
        test_random_fields(2'd0, 1'b1, 1'b0);
        test_random_fields(2'd0, 1'b0, 1'b0);
        test_random_fields(2'd1, 1'b1, 1'b0);
        test_random_fields(2'd1, 1'b0, 1'b0);
        test_random_fields(2'd2, 1'b0, 1'b1);
        test_random_fields(2'd3, 1'b1, 1'b0);
        test_random_fields(2'd3, 1'b0, 1'b0);
        test_random_fields(2'd2, 1'b1, 1'b0);

        wait_for_results();
        $display("sent %0d characters in %0d fields over %0d width/sign settings",
                 chars_sent, fields_sent, settings_used);
        $display("checked %0d results, %0d mismatches", results_checked, errors);
        if (errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
